>>> hdl/stbs_pkg.sv
package stbs_pkg;

   // table geometry
   localparam int DEPTH  = 1024;
   localparam int DATA_W = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   // search bounds carry a sign so that an upper bound of -1 is representable
   localparam int BND_W  = CNT_W + 1;
   localparam int POS_W  = 11;

   // transaction function codes
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [POS_W-1:0] position;
   } result_type;

endpackage

>>> hdl/stbs_mem.sv
module stbs_mem (
   input  logic                        clock,
   input  stbs_pkg::mem_req_type       mem_req,
   output logic [stbs_pkg::DATA_W-1:0] rd_data_ff
);
   import stbs_pkg::*;

   logic [DATA_W-1:0] store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= store_ff[mem_req.rd_addr];
   end

endmodule

>>> hdl/stbs_ctrl.sv
module stbs_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_func,
   input  logic [stbs_pkg::DATA_W-1:0] req_value,
   input  logic                        req_first,
   output logic                        req_stall,
   output stbs_pkg::mem_req_type       mem_req,
   input  logic [stbs_pkg::DATA_W-1:0] rd_data,
   output stbs_pkg::result_type        result,
   input  logic                        rsp_free
);
   import stbs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_CMP,
      ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [DATA_W-1:0]        key_ff, key_in;
   logic signed [BND_W-1:0]  lo_ff, lo_in;
   logic signed [BND_W-1:0]  hi_ff, hi_in;
   logic [ADDR_W-1:0]        mid_ff, mid_in;
   logic                     found_ff, found_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;

   logic signed [BND_W:0]    sum_w;
   logic [ADDR_W-1:0]        mid_w;
   logic signed [BND_W-1:0]  mid_s;
   logic [CNT_W-1:0]         base_w;

   // midpoint of the bounds; both are non-negative whenever a probe is issued
   assign sum_w = {lo_ff[BND_W-1], lo_ff} + {hi_ff[BND_W-1], hi_ff};
   assign mid_w = sum_w[ADDR_W:1];
   assign mid_s = signed'(BND_W'(mid_ff));

   // load slot: a first flag restarts the table at slot zero
   assign base_w = req_first ? '0 : count_ff;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      key_in          = key_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      found_in        = found_ff;
      pos_in          = pos_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = base_w[ADDR_W-1:0];
      mem_req.wr_data = req_value;
      mem_req.rd_addr = mid_w;
      result.valid    = 1'b0;
      result.found    = found_ff;
      result.position = POS_W'(pos_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_SEARCH) begin
                  key_in   = req_value;
                  lo_in    = '0;
                  hi_in    = signed'(BND_W'(count_ff)) - BND_W'(1);
                  state_in = ST_CALC;
               end else if (base_w < CNT_W'(DEPTH)) begin
                  mem_req.wr_en = 1'b1;
                  count_in      = base_w + CNT_W'(1);
               end
            end
         end
         ST_CALC: begin
            if (lo_ff > hi_ff) begin
               found_in = 1'b0;
               pos_in   = '0;
               state_in = ST_DONE;
            end else begin
               mid_in   = mid_w;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (rd_data == key_ff) begin
               found_in = 1'b1;
               pos_in   = CNT_W'(mid_ff) + CNT_W'(1);
               state_in = ST_DONE;
            end else begin
               if ($signed(key_ff) < $signed(rd_data)) begin
                  hi_in = mid_s - BND_W'(1);
               end else begin
                  lo_in = mid_s + BND_W'(1);
               end
               state_in = ST_CALC;
            end
         end
         ST_DONE: begin
            result.valid = 1'b1;
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      key_ff   <= key_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
   end

endmodule

>>> hdl/sorted_table_binary_search_core.sv
// Sorted table with binary search. A transaction with req_func low loads
// req_value into the next table slot (req_first high restarts the table at
// slot zero; loads past the table depth are dropped) and gives no response.
// A transaction with req_func high searches the loaded entries, expected in
// ascending signed order, by halving, and gives one response: rsp_found and
// the 1-based rsp_position of the matching entry, or 0. A load is written
// without leaving the idle state. Each probe of a search issues a registered
// table read at the midpoint of the bounds (ST_CALC) and compares the read
// entry with the key (ST_CMP), until a match or until the bounds cross; all
// probes share one compare. req_stall is high from the acceptance of a search
// until its response enters the output register, where a finished response
// waits so that the next transaction can be taken meanwhile.
module sorted_table_binary_search_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [stbs_pkg::DATA_W-1:0] req_value,
   input  logic                        req_first,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic [stbs_pkg::POS_W-1:0]  rsp_position
);
   import stbs_pkg::*;

   mem_req_type       mem_req;
   logic [DATA_W-1:0] rd_data;
   result_type        result;
   logic              rsp_free;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]  rsp_position_ff, rsp_position_in;

   // output register can take a new response when empty or being drained
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // sequencer, bounds and the shared compare
   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_value (req_value),
      .req_first (req_first),
      .req_stall (req_stall),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .result    (result),
      .rsp_free  (rsp_free)
   );

   // table storage, registered read
   stbs_mem u_mem (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (rd_data)
   );

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      // a finished search moves into the output register
      if (result.valid && rsp_free) begin
         rsp_valid_in    = 1'b1;
         rsp_found_in    = result.found;
         rsp_position_in = result.position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule

>>> hdl/stbs_checker.sv
module stbs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_func,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_found,
   input logic [stbs_pkg::POS_W-1:0]  rsp_position
);
   import stbs_pkg::*;

   // no response is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response stays presented
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_found) && $stable(rsp_position)))
      else $error("stalled response changed");

   // a load transaction never produces a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func == FUNC_LOAD && !rsp_valid) |=> !rsp_valid)
      else $error("response after a load");

   // an accepted search keeps the block busy
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func != FUNC_LOAD) |=> req_stall)
      else $error("search accepted without going busy");

   // found and a nonzero position go together
   a_pos_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_position != '0)))
      else $error("position does not match found flag");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (.*);
